// ===== rtl/fra_pkg.sv =====
// Shared types, constants and codes of the fragment reassembly tracker.
// Used by fra_ctx_table, fra_frag_logic and fragment_reassembly_tracker.
`timescale 1ns / 1ps
`default_nettype none

package fra_pkg;

  localparam int CONTEXT_SLOTS = 8;
  localparam int SLOT_W        = 3;
  localparam int MAX_FRAGMENTS = 64;
  localparam int BIT_W         = $clog2(MAX_FRAGMENTS);
  localparam int CNT_W         = $clog2(MAX_FRAGMENTS + 1);
  localparam int EXP_W         = $clog2(CONTEXT_SLOTS + 1);
  localparam int TIMEOUT_W     = 20;
  localparam int FSIZE_W       = 12;
  localparam int PROD_W        = BIT_W + FSIZE_W;
  localparam int OFFSET_W      = 17;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd5000;
  localparam logic [FSIZE_W-1:0]   FSIZE_RST   = 12'd1400;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_FSIZE   = 1'b1;

  localparam logic ACT_FRAGMENT = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef enum logic [2:0] {
    ST_NEW  = 3'd0,
    ST_DUP  = 3'd1,
    ST_FULL = 3'd2,
    ST_BAD  = 3'd3,
    ST_TICK = 3'd4
  } status_e;

  typedef struct packed {
    logic        action;
    logic [31:0] message_id;
    logic [31:0] message_length;
    logic [15:0] fragment_total;
    logic [15:0] fragment_number;
    logic [15:0] chunk_length;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot_used;
    logic                write_enable;
    logic [OFFSET_W-1:0] write_offset;
    logic                message_done;
    logic [31:0]         done_id;
    logic [31:0]         done_length;
    logic [EXP_W-1:0]    expired_count;
  } result_t;

  // Table view of the context that the current fragment maps to.
  typedef struct packed {
    logic                     hit;
    logic                     free_ok;
    logic [SLOT_W-1:0]        slot;
    logic [31:0]              length;
    logic [CNT_W-1:0]         total;
    logic [CNT_W-1:0]         received;
    logic [MAX_FRAGMENTS-1:0] bitmap;
    logic [EXP_W-1:0]         expired_count;
  } lookup_t;

  // Changes to the selected context.
  typedef struct packed {
    logic                     alloc;
    logic                     write_ctx;
    logic                     release_slot;
    logic [SLOT_W-1:0]        slot;
    logic [CNT_W-1:0]         received_d;
    logic [MAX_FRAGMENTS-1:0] bitmap_d;
  } update_t;

endpackage

`default_nettype wire

// ===== rtl/fra_ctx_table.sv =====
// Context slot table: storage, millisecond clock, timeout aging and id match.
// Depends on fra_pkg for the lookup and update structs.
`timescale 1ns / 1ps
`default_nettype none

module fra_ctx_table import fra_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire item_t                item_i,
  input  wire logic [TIMEOUT_W-1:0] timeout_i,
  input  wire update_t              upd_i,
  output lookup_t                   lookup_o
);

  logic [CONTEXT_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]              time_q, now;
  logic [31:0]              id_q       [CONTEXT_SLOTS];
  logic [31:0]              length_q   [CONTEXT_SLOTS];
  logic [CNT_W-1:0]         total_q    [CONTEXT_SLOTS];
  logic [CNT_W-1:0]         received_q [CONTEXT_SLOTS];
  logic [MAX_FRAGMENTS-1:0] bitmap_q   [CONTEXT_SLOTS];
  logic [31:0]              start_q    [CONTEXT_SLOTS];

  logic [CONTEXT_SLOTS-1:0] aged, live;
  logic [EXP_W-1:0]         n_expired;
  logic                     hit, free_ok;
  logic [SLOT_W-1:0]        hit_slot, free_slot, sel;

  assign now = time_q + 32'(item_i.action);

  always_comb begin
    aged      = '0;
    live      = '0;
    n_expired = '0;
    hit       = 1'b0;
    free_ok   = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int s = CONTEXT_SLOTS - 1; s >= 0; s--) begin
      aged[s] = valid_q[s] && ((now - start_q[s]) > {12'b0, timeout_i});
      live[s] = valid_q[s] && !aged[s];
      n_expired = n_expired + EXP_W'(aged[s]);
      if (live[s] && id_q[s] == item_i.message_id) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
      if (!live[s]) begin
        free_ok   = 1'b1;
        free_slot = SLOT_W'(s);
      end
    end
    sel = hit ? hit_slot : free_slot;
  end

  always_comb begin
    lookup_o.hit           = hit;
    lookup_o.free_ok       = free_ok;
    lookup_o.slot          = sel;
    lookup_o.length        = length_q[sel];
    lookup_o.total         = total_q[sel];
    lookup_o.received      = received_q[sel];
    lookup_o.bitmap        = bitmap_q[sel];
    lookup_o.expired_count = n_expired;
  end

  always_comb begin
    valid_d = live;
    if (upd_i.alloc) begin
      valid_d[upd_i.slot] = 1'b1;
    end
    if (upd_i.release_slot) begin
      valid_d[upd_i.slot] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      time_q  <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      time_q  <= now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && upd_i.alloc) begin
      id_q[upd_i.slot]     <= item_i.message_id;
      length_q[upd_i.slot] <= item_i.message_length;
      total_q[upd_i.slot]  <= item_i.fragment_total[CNT_W-1:0];
      start_q[upd_i.slot]  <= now;
    end
    if (en_i && upd_i.write_ctx) begin
      received_q[upd_i.slot] <= upd_i.received_d;
      bitmap_q[upd_i.slot]   <= upd_i.bitmap_d;
    end
  end

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.action == ACT_TICK |=> time_q == $past(time_q) + 32'd1)
    else $error("clock did not advance on a tick");

  a_alloc_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && upd_i.alloc |-> !live[upd_i.slot])
    else $error("allocation into a live context");

  a_alloc_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && upd_i.alloc && !upd_i.release_slot |=> valid_q[$past(upd_i.slot)])
    else $error("allocated context not marked valid");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && upd_i.release_slot |=> !valid_q[$past(upd_i.slot)])
    else $error("completed context still valid");

endmodule

`default_nettype wire

// ===== rtl/fra_frag_logic.sv =====
// Fragment decision logic: validity checks, duplicate test, offset and completion.
// Depends on fra_pkg; reads the lookup from fra_ctx_table and returns its update.
`timescale 1ns / 1ps
`default_nettype none

module fra_frag_logic import fra_pkg::*; (
  input  wire item_t               item_i,
  input  wire lookup_t             lookup_i,
  input  wire logic [FSIZE_W-1:0]  fsize_i,
  output result_t                  result_o,
  output update_t                  upd_o
);

  always_comb begin
    logic [CNT_W-1:0]         eff_total;
    logic [CNT_W-1:0]         eff_rcv;
    logic [MAX_FRAGMENTS-1:0] eff_map;
    logic [MAX_FRAGMENTS-1:0] bit_sel;
    logic [31:0]              eff_len;
    logic [BIT_W-1:0]         idx;
    logic [PROD_W-1:0]        prod;
    logic [32:0]              chunk_end;
    logic                     dup;
    logic [CNT_W-1:0]         rcv_n;

    eff_total = lookup_i.hit ? lookup_i.total    : item_i.fragment_total[CNT_W-1:0];
    eff_rcv   = lookup_i.hit ? lookup_i.received : '0;
    eff_map   = lookup_i.hit ? lookup_i.bitmap   : '0;
    eff_len   = lookup_i.hit ? lookup_i.length   : item_i.message_length;
    idx       = item_i.fragment_number[BIT_W-1:0];
    bit_sel   = MAX_FRAGMENTS'(1) << idx;
    dup       = eff_map[idx];
    prod      = PROD_W'(idx) * PROD_W'(fsize_i);
    chunk_end = 33'(prod) + 33'(item_i.chunk_length);
    rcv_n     = dup ? eff_rcv : eff_rcv + CNT_W'(1);

    result_o               = '0;
    result_o.status        = ST_NEW;
    result_o.expired_count = lookup_i.expired_count;
    upd_o                  = '0;
    upd_o.slot             = lookup_i.slot;
    upd_o.received_d       = rcv_n;
    upd_o.bitmap_d         = eff_map | bit_sel;

    if (item_i.action == ACT_TICK) begin
      result_o.status = ST_TICK;
    end else if (item_i.fragment_total > 16'(MAX_FRAGMENTS)
                 || item_i.fragment_number >= item_i.fragment_total) begin
      result_o.status = ST_BAD;
    end else if (!lookup_i.hit && !lookup_i.free_ok) begin
      result_o.status = ST_FULL;
    end else begin
      result_o.slot_used = lookup_i.slot;
      upd_o.alloc        = !lookup_i.hit;
      upd_o.write_ctx    = !lookup_i.hit;
      if (item_i.fragment_number >= 16'(eff_total)) begin
        result_o.status = ST_BAD;
      end else begin
        if (dup) begin
          result_o.status = ST_DUP;
        end else begin
          result_o.status       = ST_NEW;
          result_o.write_offset = prod[OFFSET_W-1:0];
          result_o.write_enable = chunk_end <= {1'b0, eff_len};
          upd_o.write_ctx       = 1'b1;
        end
        if (rcv_n == eff_total) begin
          result_o.message_done = 1'b1;
          result_o.done_id      = item_i.message_id;
          result_o.done_length  = eff_len;
          upd_o.release_slot    = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fragment_reassembly_tracker.sv =====
// Top level of the fragment reassembly tracker: stream ports, configuration
// registers, input and result registers. Depends on fra_pkg, fra_ctx_table
// and fra_frag_logic.
//
//   Channel  Direction  Contents
//   s_*      in         tuser: action; tdata: message_id, message_length,
//                       fragment_total, fragment_number, chunk_length
//   m_*      out        tuser: status; tdata: slot_used .. expired_count
//   cfg_*    in         index 0 age limit in ticks, index 1 fragment_size
//
// A word is captured in the input register, evaluated against the slot table
// once the result register is free, and lands in the result register, from which
// the result is offered. One word per cycle is sustained while the receiver does
// not stall.
// Reset clears the slot valid bits, the clock and the registers' valid flags.
// A stalled result holds the input register; s_tready_o drops only then.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_tracker import fra_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  // [31:0] message_id, [63:32] message_length, [79:64] fragment_total,
  // [95:80] fragment_number, [111:96] chunk_length
  input  wire logic [111:0] s_tdata_i,
  // [0] action
  input  wire logic         s_tuser_i,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  // [2:0] slot_used, [3] write_enable, [20:4] write_offset, [21] message_done,
  // [53:22] done_id, [85:54] done_length, [89:86] expired_count, [95:90] zero
  output logic [95:0]       m_tdata_o,
  // [2:0] status
  output logic [2:0]        m_tuser_o,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [19:0]  cfg_wdata_i
);

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [FSIZE_W-1:0]   fsize_q;
  logic                 in_vld_q, out_vld_q, fire;
  item_t                item_q;
  result_t              result_q, result_d;
  lookup_t              lookup;
  update_t              upd;

  assign fire       = in_vld_q && (!out_vld_q || m_tready_i);
  assign s_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      fsize_q   <= FSIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_FSIZE:   fsize_q   <= cfg_wdata_i[FSIZE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_vld_q <= s_tvalid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      item_q.action          <= s_tuser_i;
      item_q.message_id      <= s_tdata_i[31:0];
      item_q.message_length  <= s_tdata_i[63:32];
      item_q.fragment_total  <= s_tdata_i[79:64];
      item_q.fragment_number <= s_tdata_i[95:80];
      item_q.chunk_length    <= s_tdata_i[111:96];
    end
    if (fire) begin
      result_q <= result_d;
    end
  end

  fra_ctx_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .item_i    (item_q),
    .timeout_i (timeout_q),
    .upd_i     (upd),
    .lookup_o  (lookup)
  );

  fra_frag_logic u_logic (
    .item_i   (item_q),
    .lookup_i (lookup),
    .fsize_i  (fsize_q),
    .result_o (result_d),
    .upd_o    (upd)
  );

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = result_q.status;
  assign m_tdata_o  = {6'b0, result_q.expired_count, result_q.done_length,
                       result_q.done_id, result_q.message_done, result_q.write_offset,
                       result_q.write_enable, result_q.slot_used};

endmodule

`default_nettype wire

// ===== tb/sv/fragment_reassembly_tracker_tb.sv =====
// Self-checking testbench for fragment_reassembly_tracker: a directed table, then random
// fragment sequences over several timeout and fragment size settings, checked word by word.
// Depends on fra_pkg and the tracker RTL.
`timescale 1ns / 1ps

module fragment_reassembly_tracker_tb;
  import fra_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int POOL        = 12;
  localparam int PHASES      = 5;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [111:0] s_tdata_i;
  logic         s_tuser_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [95:0]  m_tdata_o;
  logic [2:0]   m_tuser_o;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [19:0]  cfg_wdata_i;

  fragment_reassembly_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the context table and configuration.
  logic                     ctx_valid [CONTEXT_SLOTS];
  logic [31:0]              ctx_id    [CONTEXT_SLOTS];
  logic [31:0]              ctx_len   [CONTEXT_SLOTS];
  logic [31:0]              ctx_start [CONTEXT_SLOTS];
  logic [6:0]               ctx_total [CONTEXT_SLOTS];
  logic [6:0]               ctx_rcvd  [CONTEXT_SLOTS];
  logic [MAX_FRAGMENTS-1:0] ctx_map   [CONTEXT_SLOTS];
  logic [31:0]              clock_ms;
  logic [TIMEOUT_W-1:0]     age_limit;
  logic [FSIZE_W-1:0]       frag_bytes;

  logic [31:0] msg_id    [POOL];
  logic [31:0] msg_len   [POOL];
  logic [15:0] msg_total [POOL];
  logic [15:0] msg_next  [POOL];

  result_t pending_results [$];
  int      mismatches   = 0;
  int      results_seen = 0;
  bit      no_idle      = 1'b0;

  function automatic logic [EXP_W-1:0] drop_stale();
    logic [EXP_W-1:0] n;
    logic [31:0]      age;
    n = '0;
    for (int s = 0; s < CONTEXT_SLOTS; s++) begin
      age = clock_ms - ctx_start[s];
      if (ctx_valid[s] && age > 32'(age_limit)) begin
        ctx_valid[s] = 1'b0;
        n++;
      end
    end
    return n;
  endfunction

  function automatic result_t track_word(item_t w);
    result_t     r;
    int          hit;
    logic [63:0] prod;
    r   = '0;
    hit = -1;
    if (w.action == ACT_TICK) begin
      clock_ms++;
      r.expired_count = drop_stale();
      r.status = ST_TICK;
    end else begin
      r.expired_count = drop_stale();
      r.status = ST_NEW;
      if (w.fragment_total > MAX_FRAGMENTS || w.fragment_number >= w.fragment_total) begin
        r.status = ST_BAD;
      end else begin
        for (int s = 0; s < CONTEXT_SLOTS; s++)
          if (hit < 0 && ctx_valid[s] && ctx_id[s] == w.message_id) hit = s;
        if (hit < 0) begin
          for (int s = 0; s < CONTEXT_SLOTS; s++)
            if (hit < 0 && !ctx_valid[s]) hit = s;
          if (hit >= 0) begin
            ctx_valid[hit] = 1'b1;
            ctx_id[hit]    = w.message_id;
            ctx_len[hit]   = w.message_length;
            ctx_total[hit] = w.fragment_total[6:0];
            ctx_rcvd[hit]  = '0;
            ctx_map[hit]   = '0;
            ctx_start[hit] = clock_ms;
          end else begin
            r.status = ST_FULL;
          end
        end
        if (hit >= 0) begin
          r.slot_used = hit[SLOT_W-1:0];
          if (w.fragment_number >= 16'(ctx_total[hit])) begin
            r.status = ST_BAD;
          end else begin
            if (ctx_map[hit][w.fragment_number[5:0]]) begin
              r.status = ST_DUP;
            end else begin
              prod = 64'(w.fragment_number) * 64'(frag_bytes);
              ctx_map[hit][w.fragment_number[5:0]] = 1'b1;
              ctx_rcvd[hit]++;
              r.write_offset = prod[OFFSET_W-1:0];
              r.write_enable = (prod + 64'(w.chunk_length)) <= 64'(ctx_len[hit]);
            end
            if (ctx_rcvd[hit] == ctx_total[hit]) begin
              r.message_done = 1'b1;
              r.done_id      = ctx_id[hit];
              r.done_length  = ctx_len[hit];
              ctx_valid[hit] = 1'b0;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic item_t frag_word(logic [31:0] id, logic [31:0] len, logic [15:0] total,
                                      logic [15:0] num, logic [15:0] chunk);
    item_t w;
    w.action          = ACT_FRAGMENT;
    w.message_id      = id;
    w.message_length  = len;
    w.fragment_total  = total;
    w.fragment_number = num;
    w.chunk_length    = chunk;
    return w;
  endfunction

  function automatic item_t tick_word();
    item_t w;
    w = '0;
    w.action = ACT_TICK;
    return w;
  endfunction

  function automatic result_t plain_result(status_e st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic void new_message(int k);
    msg_id[k]    = $urandom;
    msg_total[k] = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(9, 64))
                                                 : 16'($urandom_range(1, 8));
    msg_next[k]  = '0;
    msg_len[k]   = 32'(msg_total[k]) * 32'(frag_bytes);
  endfunction

  task automatic send_word(item_t w, bit typed, result_t want);
    result_t pred;
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= w.action;
    s_tdata_i  <= {w.chunk_length, w.fragment_number, w.fragment_total,
                   w.message_length, w.message_id};
    do @(posedge clk_i); while (!s_tready_o);
    pred = track_word(w);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [TIMEOUT_W-1:0] limit, logic [FSIZE_W-1:0] bytes);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TIMEOUT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_index_i <= CFG_FSIZE;
    cfg_wdata_i <= 20'(bytes);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    age_limit  = limit;
    frag_bytes = bytes;
  endtask

  task automatic run_random(int count);
    item_t   w;
    result_t none;
    int      k;
    int      pick;
    none = '0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        w = tick_word();
      end else if (pick < 20) begin
        w = frag_word($urandom, $urandom, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else begin
        k = $urandom_range(0, POOL - 1);
        if ($urandom_range(0, 99) < 4) new_message(k);
        w = frag_word(msg_id[k], msg_len[k], msg_total[k], 16'd0, 16'(frag_bytes));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          w.fragment_number = msg_next[k];
          msg_next[k] = (msg_next[k] + 16'd1) % msg_total[k];
        end else if (pick < 90) begin
          w.fragment_number = 16'($urandom_range(0, msg_total[k] - 1));
        end else if (pick < 95) begin
          w.fragment_number = msg_total[k] + 16'($urandom_range(0, 3));
        end else begin
          w.fragment_total  = 16'($urandom_range(1, MAX_FRAGMENTS));
          w.fragment_number = 16'($urandom_range(0, w.fragment_total - 1));
        end
        if ($urandom_range(0, 3) == 0) w.message_length = $urandom;
        if ($urandom_range(0, 3) == 0) w.chunk_length = 16'($urandom_range(0, 65535));
      end
      send_word(w, 1'b0, none);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      results_seen++;
      got.status        = status_e'(m_tuser_o);
      got.slot_used     = m_tdata_o[2:0];
      got.write_enable  = m_tdata_o[3];
      got.write_offset  = m_tdata_o[20:4];
      got.message_done  = m_tdata_o[21];
      got.done_id       = m_tdata_o[53:22];
      got.done_length   = m_tdata_o[85:54];
      got.expired_count = m_tdata_o[89:86];
      if (pending_results.size() == 0) begin
        $error("Result word arrived with no expectation pending.");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("slot_used", 32'(want.slot_used), 32'(got.slot_used));
        check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
        check_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
        check_field("message_done", 32'(want.message_done), 32'(got.message_done));
        check_field("done_id", want.done_id, got.done_id);
        check_field("done_length", want.done_length, got.done_length);
        check_field("expired_count", 32'(want.expired_count), 32'(got.expired_count));
      end
    end
  end

  // The receiver stalls at random unless no_idle is set and, once, for a long stretch so the input backs up.
  initial begin
    bit hold_done;
    hold_done  = 1'b0;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        m_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_tready_i <= no_idle || ($urandom_range(0, 99) >= 14);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || cfg_we_i)
        idle = 0;
      else
        idle++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t             dir_tbl [$];
    result_t              none;
    logic [31:0]          fill_id;
    logic [TIMEOUT_W-1:0] phase_limit [PHASES];
    logic [FSIZE_W-1:0]   phase_bytes [PHASES];

    phase_limit = '{20'd0, 20'd1000000, 20'd12, 20'd3, 20'd250};
    phase_bytes = '{12'd1, 12'd2048, 12'hFFF, 12'd1400, 12'd97};
    none        = '0;

    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_TIMEOUT;
    cfg_wdata_i = '0;
    for (int s = 0; s < CONTEXT_SLOTS; s++) ctx_valid[s] = 1'b0;
    clock_ms   = '0;
    age_limit  = TIMEOUT_RST;
    frag_bytes = FSIZE_RST;

    dir_tbl.push_back('{tick_word(), 1'b1, plain_result(ST_TICK)});
    dir_tbl.push_back('{frag_word(32'd0, 32'd0, 16'd0, 16'd0, 16'd0), 1'b1,
                        plain_result(ST_BAD)});
    dir_tbl.push_back('{frag_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                        1'b1, plain_result(ST_BAD)});
    dir_tbl.push_back('{frag_word(32'd5, 32'd1000, 16'd65, 16'd0, 16'd10), 1'b1,
                        plain_result(ST_BAD)});
    dir_tbl.push_back('{frag_word(32'd1, 32'd2800, 16'd3, 16'd0, 16'd1400), 1'b0, none});
    dir_tbl.push_back('{frag_word(32'd1, 32'd2800, 16'd3, 16'd0, 16'd1400), 1'b0, none});
    dir_tbl.push_back('{frag_word(32'd1, 32'd2800, 16'd3, 16'd2, 16'd1400), 1'b0, none});
    dir_tbl.push_back('{frag_word(32'd1, 32'd2800, 16'd5, 16'd4, 16'd1400), 1'b0, none});
    dir_tbl.push_back('{frag_word(32'd1, 32'd99, 16'd9, 16'd1, 16'd0), 1'b0, none});
    dir_tbl.push_back('{frag_word(32'd2, 32'd0, 16'd1, 16'd0, 16'hFFFF), 1'b0, none});
    for (int i = 0; i < CONTEXT_SLOTS; i++) begin
      fill_id = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : 32'(i + 8);
      dir_tbl.push_back('{frag_word(fill_id, 32'd89600, 16'd64, 16'd63, 16'd1400), 1'b0, none});
    end
    dir_tbl.push_back('{frag_word(32'd18, 32'd100, 16'd2, 16'd0, 16'd100), 1'b1,
                        plain_result(ST_FULL)});
    dir_tbl.push_back('{frag_word(32'hFFFF_FFFF, 32'd89600, 16'd64, 16'd63, 16'd1400), 1'b0,
                        none});
    dir_tbl.push_back('{frag_word(32'd11, 32'hFFFF_FFFF, 16'd64, 16'd0, 16'hFFFF), 1'b0, none});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_word(dir_tbl[i].word, dir_tbl[i].typed, dir_tbl[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_limit[p], phase_bytes[p]);
      for (int k = 0; k < POOL; k++) new_message(k);
      no_idle = (p == 2);
      run_random(200);
      drain();
    end
    repeat (6) @(posedge clk_i);

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
